FILE: design/stac_pkg.sv
// Shared types and constants for the signed timespec ALU.
package stac_pkg;

  typedef logic signed [63:0] sec_t;
  typedef logic signed [30:0] nsec_t;
  typedef logic signed [31:0] factor_t;
  typedef logic signed [33:0] nwide_t;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_SUB  = 3'd1,
    OP_NEG  = 3'd2,
    OP_MUL  = 3'd3,
    OP_TEST = 3'd4
  } op_t;

  localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
  localparam nwide_t      NS_WIDE    = 34'sd1000000000;

  // 1e9 = 2^9 * NS_ODD
  localparam logic [20:0] NS_ODD     = 21'd1953125;
  localparam int          NS_SHIFT   = 9;

  // floor(2^64 / 1e9) split at bit 32
  localparam logic [31:0] RECIP_LO   = 32'h4B82FA09;
  localparam logic [2:0]  RECIP_HI   = 3'd4;

endpackage

FILE: design/stac_if.sv
// Valid/ready channel interfaces for operand and result beats.
interface stac_in_if;
  import stac_pkg::*;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  sec_t       a_seconds;
  nsec_t      a_nanos;
  sec_t       b_seconds;
  nsec_t      b_nanos;
  factor_t    factor;

  modport source (output valid, kind, a_seconds, a_nanos, b_seconds, b_nanos, factor,
                  input ready);
  modport sink (input valid, kind, a_seconds, a_nanos, b_seconds, b_nanos, factor,
                output ready);
endinterface

interface stac_out_if;
  import stac_pkg::*;
  logic  valid;
  logic  ready;
  sec_t  result_seconds;
  nsec_t result_nanos;
  logic  is_negative;

  modport source (output valid, result_seconds, result_nanos, is_negative, input ready);
  modport sink (input valid, result_seconds, result_nanos, is_negative, output ready);
endinterface

FILE: design/stac_div.sv
// Four-stage divide of a 64-bit magnitude by one billion (reciprocal multiply, one fixup).
module stac_div (
  input  logic        clk,
  input  logic [3:0]  adv,
  input  logic [63:0] mag,
  output logic [34:0] quo,
  output logic [29:0] rem
);
  import stac_pkg::*;

  logic [63:0] pl_r;
  logic [63:0] ph_r;
  logic [34:0] pm_r;
  logic [34:0] pt_r;
  logic [30:0] mag_a_r;
  logic [34:0] qe_r;
  logic [30:0] mag_b_r;
  logic [34:0] qc_r;
  logic [30:0] rc_r;
  logic [34:0] quo_r;
  logic [29:0] rem_r;
  logic [98:0] acc;
  logic [21:0] lowp;

  // partial products of mag * floor(2^64/1e9)
  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pl_r    <= mag[31:0] * RECIP_LO;
      ph_r    <= mag[63:32] * RECIP_LO;
      pm_r    <= mag[31:0] * RECIP_HI;
      pt_r    <= mag[63:32] * RECIP_HI;
      mag_a_r <= mag[30:0];
    end
  end

  assign acc = 99'(pl_r) + (99'(ph_r) << 32) + (99'(pm_r) << 32) + (99'(pt_r) << 64);

  // estimate is exact or one low
  always_ff @(posedge clk) begin
    if (adv[1]) begin
      qe_r    <= acc[98:64];
      mag_b_r <= mag_a_r;
    end
  end

  // remainder stays below 2e9, so the low 31 bits suffice
  assign lowp = 22'(qe_r[21:0] * NS_ODD);

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      qc_r <= qe_r;
      rc_r <= mag_b_r - {lowp, {NS_SHIFT{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      if (rc_r >= 31'(NS_PER_SEC)) begin
        quo_r <= qc_r + 35'd1;
        rem_r <= 30'(rc_r - 31'(NS_PER_SEC));
      end else begin
        quo_r <= qc_r;
        rem_r <= rc_r[29:0];
      end
    end
  end

  assign quo = quo_r;
  assign rem = rem_r;

endmodule

FILE: design/signed_timespec_alu_core.sv
// Top level: ten-stage pipelined timespec add/sub/negate/multiply/test unit.
//
//   channel  dir  beat payload
//   in_ch    in   kind, a_seconds, a_nanos, b_seconds, b_nanos, factor
//   out_ch   out  result_seconds, result_nanos, is_negative
//
// One beat per cycle sustained while out_ch.ready is high; out_ch.valid rises
// after ten register stages (the tenth is the output register).
// Latency is set by the multiply path: a_seconds*1e9, times factor, absolute
// value, then the four-stage divide by 1e9 in stac_div.
// rst_n (synchronous) clears the stage valid bits only.
// A stage holds only when it is full and the stage after it cannot load, so
// bubbles close up and in_ch.ready stays high while the output stage is empty.
module signed_timespec_alu_core (
  input logic        clk,
  input logic        rst_n,
  stac_in_if.sink    in_ch,
  stac_out_if.source out_ch
);
  import stac_pkg::*;

  localparam int NSTG = 10;

  typedef struct packed {
    logic [2:0] kind;
    logic       tneg;
    logic       mneg;
    sec_t       res_s;
    nsec_t      res_n;
  } side_t;

  logic [NSTG:1]   vld_r;
  logic [NSTG:1]   vld_nxt;
  logic [NSTG+1:1] adv;

  side_t side_r   [1:NSTG-1];
  side_t side_nxt [1:NSTG-1];

  // add path
  sec_t        s1_as_r;
  nsec_t       s1_an_r;
  sec_t        s1_bs_r;
  nwide_t      s1_bn_r;
  sec_t        s2_s_r;
  nwide_t      s2_n_r;
  sec_t        s3_s_r;
  nwide_t      s3_n_r;
  nwide_t      a_nw;
  nwide_t      b_nw;
  nwide_t      na;
  nwide_t      nb;
  sec_t        c_s;
  nwide_t      c_n;
  sec_t        s_inc;
  sec_t        r_s;
  nwide_t      r_n;

  // multiply path
  logic [61:0] s1_p0_r;
  logic [31:0] s1_p1_r;
  nwide_t      s1_sn_r;
  logic [31:0] s1_f_r;
  logic [63:0] s2_t_r;
  logic [31:0] s2_f_r;
  logic [63:0] s3_pl_r;
  logic [31:0] s3_ph_r;
  logic [63:0] s4_tp_r;
  logic [63:0] s5_mag_r;
  logic [34:0] div_quo;
  logic [29:0] div_rem;
  logic [63:0] q64;
  sec_t        mul_s;
  nsec_t       mul_n;

  // output stage
  sec_t        out_s_r;
  nsec_t       out_n_r;
  logic        out_neg_r;
  sec_t        fin_s;
  nsec_t       fin_n;
  logic        fin_neg;

  logic        is_sub;
  logic        bs_zero;
  logic        as_zero;

  // stage load enables and valid bits
  always_comb begin
    adv[NSTG+1] = out_ch.ready;
    for (int k = NSTG; k >= 1; k--) begin
      adv[k] = !vld_r[k] || adv[k+1];
    end
  end

  assign vld_nxt     = {vld_r[NSTG-1:1], in_ch.valid};
  assign in_ch.ready = adv[1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      for (int k = 1; k <= NSTG; k++) begin
        if (adv[k]) begin
          vld_r[k] <= vld_nxt[k];
        end
      end
    end
  end

  // stage 1: operand prep, negate op, test flag, a_seconds*1e9 partials
  assign is_sub  = (in_ch.kind == OP_SUB);
  assign bs_zero = (in_ch.b_seconds == '0);
  assign as_zero = (in_ch.a_seconds == '0);
  assign a_nw    = nwide_t'(in_ch.a_nanos);
  assign b_nw    = nwide_t'(in_ch.b_nanos);

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_as_r <= in_ch.a_seconds;
      s1_an_r <= in_ch.a_nanos;
      s1_bs_r <= (is_sub && !bs_zero) ? -in_ch.b_seconds : in_ch.b_seconds;
      s1_bn_r <= (is_sub && bs_zero) ? -b_nw : b_nw;
      s1_p0_r <= in_ch.a_seconds[31:0] * NS_PER_SEC;
      s1_p1_r <= 32'(in_ch.a_seconds[63:32] * NS_PER_SEC);
      s1_sn_r <= in_ch.a_seconds[63] ? -a_nw : a_nw;
      s1_f_r  <= in_ch.factor;
    end
  end

  // stage 2: signed nanos and sums; t = a*1e9 + nanos
  always_comb begin
    na = s1_as_r[63] ? -nwide_t'(s1_an_r) : nwide_t'(s1_an_r);
    nb = s1_bs_r[63] ? -s1_bn_r : s1_bn_r;
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_s_r <= s1_as_r + s1_bs_r;
      s2_n_r <= na + nb;
      s2_t_r <= 64'(s1_p0_r) + {s1_p1_r, 32'b0} + {{30{s1_sn_r[33]}}, s1_sn_r};
      s2_f_r <= s1_f_r;
    end
  end

  // stage 3: carry at one billion; t*factor partials
  always_comb begin
    c_s = s2_s_r;
    c_n = s2_n_r;
    if (s2_n_r >= NS_WIDE) begin
      c_s = s2_s_r + 64'sd1;
      c_n = s2_n_r - NS_WIDE;
    end else if (s2_n_r <= -NS_WIDE) begin
      c_s = s2_s_r - 64'sd1;
      c_n = s2_n_r + NS_WIDE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_s_r  <= c_s;
      s3_n_r  <= c_n;
      s3_pl_r <= s2_t_r[31:0] * s2_f_r;
      s3_ph_r <= 32'(s2_t_r[63:32] * s2_f_r) + (s2_f_r[31] ? 32'd0 - s2_t_r[31:0] : 32'd0);
    end
  end

  // stage 4: recombine into sign convention; low 64 bits of product
  always_comb begin
    r_s   = s3_s_r;
    r_n   = s3_n_r;
    s_inc = s3_s_r + 64'sd1;
    if (s3_s_r[63]) begin
      if (s3_n_r < 0) begin
        r_n = -s3_n_r;
      end else if (s3_n_r > 0) begin
        r_s = s_inc;
        r_n = (s_inc == '0) ? s3_n_r - NS_WIDE : NS_WIDE - s3_n_r;
      end
    end else if (s3_s_r != '0 && s3_n_r < 0) begin
      r_s = s3_s_r - 64'sd1;
      r_n = NS_WIDE + s3_n_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_tp_r <= s3_pl_r + {s3_ph_r, 32'b0};
    end
  end

  // stage 5: magnitude
  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_mag_r <= s4_tp_r[63] ? 64'd0 - s4_tp_r : s4_tp_r;
    end
  end

  // side data riding along with each beat
  always_comb begin
    side_nxt[1].kind  = in_ch.kind;
    side_nxt[1].tneg  = in_ch.a_seconds[63] | in_ch.a_nanos[30];
    side_nxt[1].mneg  = 1'b0;
    side_nxt[1].res_s = '0;
    side_nxt[1].res_n = '0;
    if (in_ch.kind == OP_NEG) begin
      side_nxt[1].res_s = as_zero ? sec_t'(0) : -in_ch.a_seconds;
      side_nxt[1].res_n = as_zero ? -in_ch.a_nanos : in_ch.a_nanos;
    end
    for (int k = 2; k <= NSTG-1; k++) begin
      side_nxt[k] = side_r[k-1];
    end
    if (side_r[3].kind == OP_ADD || side_r[3].kind == OP_SUB) begin
      side_nxt[4].res_s = r_s;
      side_nxt[4].res_n = r_n[30:0];
    end
    side_nxt[5].mneg = s4_tp_r[63];
  end

  always_ff @(posedge clk) begin
    for (int k = 1; k <= NSTG-1; k++) begin
      if (adv[k]) begin
        side_r[k] <= side_nxt[k];
      end
    end
  end

  // stages 6..9
  stac_div u_div (
    .clk (clk),
    .adv (adv[9:6]),
    .mag (s5_mag_r),
    .quo (div_quo),
    .rem (div_rem)
  );

  // stage 10: restore sign, select result
  always_comb begin
    q64   = 64'(div_quo);
    mul_s = side_r[9].mneg ? sec_t'(64'd0 - q64) : sec_t'(q64);
    mul_n = (side_r[9].mneg && div_quo == '0) ? -nsec_t'({1'b0, div_rem})
                                              : nsec_t'({1'b0, div_rem});
    case (side_r[9].kind)
      OP_MUL: begin
        fin_s   = mul_s;
        fin_n   = mul_n;
        fin_neg = mul_s[63] | mul_n[30];
      end
      OP_TEST: begin
        fin_s   = '0;
        fin_n   = '0;
        fin_neg = side_r[9].tneg;
      end
      default: begin
        fin_s   = side_r[9].res_s;
        fin_n   = side_r[9].res_n;
        fin_neg = side_r[9].res_s[63] | side_r[9].res_n[30];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv[NSTG]) begin
      out_s_r   <= fin_s;
      out_n_r   <= fin_n;
      out_neg_r <= fin_neg;
    end
  end

  assign out_ch.valid          = vld_r[NSTG];
  assign out_ch.result_seconds = out_s_r;
  assign out_ch.result_nanos   = out_n_r;
  assign out_ch.is_negative    = out_neg_r;

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !vld_r[NSTG] |-> in_ch.ready)
    else $error("input stalled with empty output stage");

  a_div_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[9] |-> (div_rem < NS_PER_SEC))
    else $error("divide remainder not reduced");

  a_test_side_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[9] && side_r[9].kind == OP_TEST) |-> (side_r[9].res_s == '0 && side_r[9].res_n == '0))
    else $error("test beat carries nonzero result fields");

  a_out_hold_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[NSTG] && !out_ch.ready) |=> vld_r[NSTG] && !in_ch.ready == !adv[1])
    else $error("stalled output beat dropped");

endmodule

FILE: sim/tb_signed_timespec_alu_core.sv
// Testbench for signed_timespec_alu_core: directed and random beats checked against a predictor.
`timescale 1ns / 100ps

module tb_signed_timespec_alu_core;
  import stac_pkg::*;

  localparam longint NSEC_PER_SEC = 1000000000;
  localparam int     QUIET_LIMIT  = 4000;
  localparam sec_t   SEC_MIN      = {1'b1, {63{1'b0}}};
  localparam sec_t   SEC_MAX      = {1'b0, {63{1'b1}}};
  localparam nsec_t  NSEC_MIN     = {1'b1, {30{1'b0}}};
  localparam nsec_t  NSEC_MAX     = {1'b0, {30{1'b1}}};

  typedef struct {
    logic [2:0] kind;
    sec_t       a_secs;
    nsec_t      a_nanos;
    sec_t       b_secs;
    nsec_t      b_nanos;
    factor_t    factor;
  } ts_op_t;

  typedef struct {
    sec_t  secs;
    nsec_t nanos;
    logic  neg;
  } ts_result_t;

  logic clk;
  logic rst_n;

  stac_in_if  in_bus();
  stac_out_if out_bus();

  signed_timespec_alu_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  ts_result_t awaited_results[$];
  int         fail_count   = 0;
  int         quiet_cycles = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;
  ts_result_t got_res;
  ts_result_t exp_res;

  // ---------------------------------------------------------------- predictor

  function automatic void ts_add(input logic [63:0] as, input longint an,
                                 input logic [63:0] bs, input longint bn,
                                 output logic [63:0] rs, output longint rn);
    logic [63:0] s;
    longint      n;
    s = as + bs;
    n = (as[63] ? -an : an) + (bs[63] ? -bn : bn);
    if (n >= NSEC_PER_SEC) begin
      s = s + 64'd1;
      n = n - NSEC_PER_SEC;
    end else if (n <= -NSEC_PER_SEC) begin
      s = s - 64'd1;
      n = n + NSEC_PER_SEC;
    end
    // fold back into the sign convention
    if (s[63]) begin
      if (n < 0) begin
        n = -n;
      end else if (n > 0) begin
        s = s + 64'd1;
        if (s == 64'd0) n = n - NSEC_PER_SEC;
        else n = NSEC_PER_SEC - n;
      end
    end else if (s != 64'd0 && n < 0) begin
      s = s - 64'd1;
      n = NSEC_PER_SEC + n;
    end
    rs = s;
    rn = n;
  endfunction

  function automatic void ts_negate(input logic [63:0] as, input longint an,
                                    output logic [63:0] rs, output longint rn);
    if (as != 64'd0) begin
      rs = 64'd0 - as;
      rn = an;
    end else begin
      rs = 64'd0;
      rn = -an;
    end
  endfunction

  function automatic void ts_scale(input logic [63:0] as, input longint an,
                                   input factor_t f,
                                   output logic [63:0] rs, output longint rn);
    logic [63:0] t;
    logic [63:0] sn;
    logic [63:0] mag;
    logic [63:0] q;
    logic [63:0] r;
    longint      n;
    logic        neg;
    sn  = as[63] ? -an : an;
    t   = as * 64'd1000000000 + sn;
    t   = t * {{32{f[31]}}, f};
    neg = t[63];
    mag = neg ? 64'd0 - t : t;
    q   = mag / 64'd1000000000;
    r   = mag % 64'd1000000000;
    n   = r;
    if (neg) begin
      q = 64'd0 - q;
      n = -n;
    end
    if (q[63] && n < 0) n = -n;
    rs = q;
    rn = n;
  endfunction

  function automatic ts_result_t calc_timespec(ts_op_t op);
    ts_result_t  res;
    logic [63:0] rs;
    logic [63:0] ns;
    longint      rn;
    longint      nn;
    longint      an;
    longint      bn;
    an = op.a_nanos;
    bn = op.b_nanos;
    rs = 64'd0;
    rn = 0;
    case (op.kind)
      OP_ADD: ts_add(op.a_secs, an, op.b_secs, bn, rs, rn);
      OP_SUB: begin
        ts_negate(op.b_secs, bn, ns, nn);
        ts_add(op.a_secs, an, ns, nn, rs, rn);
      end
      OP_NEG: ts_negate(op.a_secs, an, rs, rn);
      OP_MUL: ts_scale(op.a_secs, an, op.factor, rs, rn);
      default: ;
    endcase
    res.secs  = rs;
    res.nanos = rn[30:0];
    res.neg   = rs[63] | rn[30];
    if (op.kind == OP_TEST) begin
      res.secs  = '0;
      res.nanos = '0;
      res.neg   = op.a_secs[63] | op.a_nanos[30];
    end
    return res;
  endfunction

  // ---------------------------------------------------------------- clock, reset, sink

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      out_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------- scoreboard

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready) begin
        awaited_results.push_back(calc_timespec('{in_bus.kind, in_bus.a_seconds,
            in_bus.a_nanos, in_bus.b_seconds, in_bus.b_nanos, in_bus.factor}));
      end
      if (out_bus.valid && out_bus.ready) begin
        got_res = '{out_bus.result_seconds, out_bus.result_nanos, out_bus.is_negative};
        if (awaited_results.size() == 0) begin
          $error("result beat with nothing outstanding: seconds %0d nanos %0d",
                 got_res.secs, got_res.nanos);
          fail_count++;
        end else begin
          exp_res = awaited_results.pop_front();
          if (got_res.secs !== exp_res.secs) begin
            $error("result_seconds: expected %0d, got %0d", exp_res.secs, got_res.secs);
            fail_count++;
          end
          if (got_res.nanos !== exp_res.nanos) begin
            $error("result_nanos: expected %0d, got %0d", exp_res.nanos, got_res.nanos);
            fail_count++;
          end
          if (got_res.neg !== exp_res.neg) begin
            $error("is_negative: expected %0b, got %0b", exp_res.neg, got_res.neg);
            fail_count++;
          end
        end
      end
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus helpers

  task automatic send_op(input ts_op_t op);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(posedge clk);
    end
    in_bus.valid     <= 1'b1;
    in_bus.kind      <= op.kind;
    in_bus.a_seconds <= op.a_secs;
    in_bus.a_nanos   <= op.a_nanos;
    in_bus.b_seconds <= op.b_secs;
    in_bus.b_nanos   <= op.b_nanos;
    in_bus.factor    <= op.factor;
    do @(posedge clk); while (!in_bus.ready);
  endtask

  // lower valid and hold until every outstanding result has come back
  task automatic drain_results();
    in_bus.valid <= 1'b0;
    do @(posedge clk); while (awaited_results.size() != 0);
  endtask

  function automatic ts_op_t mk_op(logic [2:0] kind, sec_t as, nsec_t an,
                                   sec_t bs, nsec_t bn, factor_t f);
    ts_op_t op;
    op = '{kind, as, an, bs, bn, f};
    return op;
  endfunction

  function automatic sec_t rand_secs();
    case ($urandom_range(0, 9))
      0: return '0;
      1, 2, 3: return sec_t'(longint'($urandom_range(0, 20)) - 10);
      4, 5: return sec_t'(int'($urandom));
      6, 7: return {$urandom, $urandom};
      default: begin
        case ($urandom_range(0, 4))
          0: return SEC_MIN;
          1: return SEC_MAX;
          2: return SEC_MIN + 64'sd1;
          3: return SEC_MAX - 64'sd1;
          default: return -64'sd1;
        endcase
      end
    endcase
  endfunction

  function automatic nsec_t rand_nanos(sec_t s);
    nsec_t n;
    case ($urandom_range(0, 5))
      0: n = '0;
      1: n = 31'sd999999999;
      2: n = 31'sd1;
      default: n = nsec_t'($urandom_range(0, 999999999));
    endcase
    if (s == '0 && $urandom_range(0, 1) == 1) n = -n;
    if ($urandom_range(0, 9) == 0) n = nsec_t'($urandom);
    return n;
  endfunction

  function automatic factor_t rand_factor();
    case ($urandom_range(0, 5))
      0: return factor_t'(int'($urandom_range(0, 6)) - 3);
      1: return factor_t'($urandom);
      2: begin
        case ($urandom_range(0, 2))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          default: return -32'sd1;
        endcase
      end
      default: return factor_t'(int'($urandom_range(0, 2000)) - 1000);
    endcase
  endfunction

  function automatic ts_op_t rand_op();
    ts_op_t op;
    if ($urandom_range(0, 99) < 6) op.kind = 3'($urandom_range(5, 7));
    else op.kind = 3'($urandom_range(0, 4));
    op.a_secs  = rand_secs();
    op.a_nanos = rand_nanos(op.a_secs);
    op.b_secs  = rand_secs();
    op.b_nanos = rand_nanos(op.b_secs);
    op.factor  = rand_factor();
    return op;
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_directed();
    // carry, borrow, and recombination into the sign convention
    send_op(mk_op(OP_ADD, 64'sd1, 31'sd500000000, 64'sd2, 31'sd700000000, 32'sd0));
    send_op(mk_op(OP_ADD, -64'sd1, 31'sd500000000, -64'sd2, 31'sd700000000, 32'sd0));
    send_op(mk_op(OP_ADD, 64'sd0, -31'sd300000000, 64'sd0, 31'sd100000000, 32'sd0));
    send_op(mk_op(OP_ADD, 64'sd1, 31'sd0, -64'sd1, 31'sd500000000, 32'sd0));
    send_op(mk_op(OP_ADD, -64'sd1, 31'sd200000000, 64'sd1, 31'sd0, 32'sd0));
    send_op(mk_op(OP_ADD, SEC_MAX, 31'sd999999999, 64'sd0, 31'sd999999999, 32'sd0));
    send_op(mk_op(OP_ADD, SEC_MIN, 31'sd0, -64'sd1, 31'sd999999999, 32'sd0));
    // nanoseconds outside the legal range
    send_op(mk_op(OP_ADD, 64'sd3, NSEC_MIN, -64'sd4, NSEC_MAX, 32'sd0));
    send_op(mk_op(OP_SUB, 64'sd5, 31'sd100000000, 64'sd2, 31'sd900000000, 32'sd0));
    send_op(mk_op(OP_SUB, 64'sd0, 31'sd5, 64'sd0, -31'sd999999999, 32'sd0));
    send_op(mk_op(OP_SUB, SEC_MIN, 31'sd1, SEC_MAX, 31'sd999999999, 32'sd0));
    // negation of the most negative seconds wraps onto itself
    send_op(mk_op(OP_NEG, SEC_MIN, 31'sd42, 64'sd0, 31'sd0, 32'sd0));
    send_op(mk_op(OP_NEG, 64'sd0, -31'sd999999999, 64'sd0, 31'sd0, 32'sd0));
    send_op(mk_op(OP_NEG, 64'sd0, 31'sd0, 64'sd0, 31'sd0, 32'sd0));
    send_op(mk_op(OP_NEG, -64'sd7, 31'sd123, 64'sd0, 31'sd0, 32'sd0));
    send_op(mk_op(OP_MUL, 64'sd1, 31'sd500000000, 64'sd0, 31'sd0, -32'sd3));
    send_op(mk_op(OP_MUL, 64'sd0, -31'sd999999999, 64'sd0, 31'sd0, 32'sh8000_0000));
    send_op(mk_op(OP_MUL, SEC_MAX, 31'sd999999999, 64'sd0, 31'sd0, 32'sh7fff_ffff));
    send_op(mk_op(OP_MUL, -64'sd2, 31'sd250000000, 64'sd0, 31'sd0, 32'sd0));
    send_op(mk_op(OP_MUL, SEC_MIN, 31'sd0, 64'sd0, 31'sd0, -32'sd1));
    send_op(mk_op(OP_TEST, -64'sd1, 31'sd0, 64'sd9, 31'sd9, 32'sd9));
    send_op(mk_op(OP_TEST, 64'sd0, -31'sd1, 64'sd0, 31'sd0, 32'sd0));
    send_op(mk_op(OP_TEST, 64'sd0, 31'sd1, SEC_MIN, -31'sd1, -32'sd1));
    // unused selectors give all-zero results
    for (int k = 5; k < 8; k++) begin
      send_op(mk_op(3'(k), SEC_MIN, -31'sd5, -64'sd1, NSEC_MIN, -32'sd1));
    end
    drain_results();
  endtask

  task automatic test_random_traffic(input int n_ops, input int s_pct, input int r_pct);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int i = 0; i < n_ops; i++) begin
      send_op(rand_op());
      if (i == n_ops / 2) drain_results();
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------- main

  initial begin
    rst_n            <= 1'b0;
    in_bus.valid     <= 1'b0;
    in_bus.kind      <= '0;
    in_bus.a_seconds <= '0;
    in_bus.a_nanos   <= '0;
    in_bus.b_seconds <= '0;
    in_bus.b_nanos   <= '0;
    in_bus.factor    <= '0;
    send_idle_pct    = 7;
    recv_idle_pct    = 72;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_traffic(270, 7, 72);
    test_random_traffic(270, 72, 7);
    test_random_traffic(270, 0, 0);

    repeat (20) @(posedge clk);
    if (awaited_results.size() != 0) begin
      $error("%0d results never arrived", awaited_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

FILE: signed_timespec_alu_core.f
design/stac_pkg.sv
design/stac_if.sv
design/stac_div.sv
design/signed_timespec_alu_core.sv
sim/tb_signed_timespec_alu_core.sv
